[sv/wakeup_source_validation_table_macros.svh]
// Assertion macros for the wakeup source validation table.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef WAKEUP_SOURCE_VALIDATION_TABLE_MACROS_SVH
`define WAKEUP_SOURCE_VALIDATION_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wsvt_pkg.sv]
// Shared types and constants for the wakeup source validation table.
// No dependencies; used by wakeup_source_validation_table.
package wsvt_pkg;

  localparam int unsigned NUM_SOURCES_DEF = 32;
  localparam int unsigned SRC_IDX_W      = 5;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam logic [15:0] TIMEOUT_NEVER  = 16'hFFFF;
  localparam logic [15:0] TICK_STEP_RST  = 16'd10;

  typedef enum logic [3:0] {
    OP_REGISTER   = 4'd0,
    OP_UNREGISTER = 4'd1,
    OP_SET_EVENT  = 4'd2,
    OP_CLEAR      = 4'd3,
    OP_VALIDATE   = 4'd4,
    OP_TICK       = 4'd5,
    OP_CHANNEL    = 4'd6,
    OP_CHECK_HOOK = 4'd7,
    OP_QUERY      = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_PENDING   = 2'd1,
    ST_VALIDATED = 2'd2,
    ST_EXPIRED   = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODULE_ENABLED = 2'd0,
    CFG_DISABLED_MASK  = 2'd1,
    CFG_TICK_STEP      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  source_index;
    logic [31:0] source_mask;
    logic [31:0] check_valid_mask;
    logic [15:0] timeout_ms;
    logic [15:0] countdown;
    logic        check_supported;
    logic        channel_supported;
    logic [7:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pending_mask;
    logic [31:0] validated_mask;
    logic [31:0] expired_mask;
    logic [1:0]  source_status;
    logic        op_ok;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] countdown;
    logic [15:0] timer;
    logic        check_en;
    logic        channel_en;
    logic [7:0]  channel;
  } slot_entry_t;

endpackage

[sv/wakeup_source_validation_table.sv]
// Wakeup source validation table: each transaction walks every slot once.
// The input stalls from acceptance until the result is registered, so one
// transaction is handled at a time; the walk reads and updates slots in turn
// through the single read and write port of the slot settings memory.
// Reset (rst, synchronous) unregisters all slots and restores the registers.
// The settings memory needs no clearing pass: registration rewrites an entry.
module wakeup_source_validation_table #(
  parameter int unsigned NUM_SOURCES = wsvt_pkg::NUM_SOURCES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wsvt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wsvt_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsvt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wsvt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wsvt_pkg::*;

  `include "wakeup_source_validation_table_macros.svh"

  localparam int unsigned IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SOURCES + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_RESULT} state_t;

  // Configuration registers. Writes are always taken.
  logic        module_enabled;
  logic [31:0] disabled_mask;
  logic [15:0] tick_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_enabled <= 1'b1;
      disabled_mask  <= '0;
      tick_step      <= TICK_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODULE_ENABLED: module_enabled <= cfg_data[0];
        CFG_DISABLED_MASK:  disabled_mask  <= cfg_data;
        CFG_TICK_STEP:      tick_step      <= cfg_data[15:0];
        default:            ;
      endcase
    end
  end

  // Sequencer state. The accepted transaction is held in item for the walk.
  state_t         state;
  in_item_t       item;
  logic [CNT_W-1:0] cnt;
  logic           ok;
  logic           found;
  logic           ok_next;
  logic           found_next;
  out_item_t      result;

  // Read pipeline: slot cnt is read in one cycle and modified in the next.
  logic             proc_vld;
  logic [IDX_W-1:0] proc_idx;
  slot_entry_t      rd_data;

  // Settings memory, plus registered marks and status in flip-flops so that
  // the result masks can be formed from all slots at once.
  slot_entry_t mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] reg_q;
  status_t stat [NUM_SOURCES];

  logic        in_accept;
  logic        walk_end;
  logic        r_next;
  status_t     s_next;
  slot_entry_t e_next;
  logic        set_ev;
  logic        hit;
  logic [16:0] tsum;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign walk_end  = (cnt == CNT_W'(NUM_SOURCES));

  always_ff @(posedge clk) begin
    rd_data <= mem[cnt[IDX_W-1:0]];
    if (proc_vld) begin
      mem[proc_idx] <= e_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= (state == S_WALK) && !walk_end;
    end
    proc_idx <= cnt[IDX_W-1:0];
  end

  // Per-slot update of the slot under modification.
  always_comb begin
    r_next     = reg_q[proc_idx];
    s_next     = stat[proc_idx];
    e_next     = rd_data;
    ok_next    = ok;
    found_next = found;
    set_ev     = 1'b0;
    hit        = (SRC_IDX_W'(proc_idx) == item.source_index);
    tsum       = {1'b0, rd_data.timer} + {1'b0, tick_step};
    case (op_t'(item.op))
      OP_REGISTER: begin
        if (hit) begin
          if (!r_next) begin
            s_next       = ST_NONE;
            e_next.timer = '0;
          end
          r_next            = 1'b1;
          e_next.timeout    = item.timeout_ms;
          e_next.countdown  = item.countdown;
          e_next.check_en   = item.check_supported;
          e_next.channel_en = item.channel_supported;
          e_next.channel    = item.channel;
        end
      end
      OP_UNREGISTER: begin
        if (hit) begin
          if (r_next) begin
            r_next = 1'b0;
            s_next = ST_NONE;
          end else begin
            ok_next = 1'b0;
          end
        end
      end
      OP_SET_EVENT: set_ev = item.source_mask[proc_idx];
      OP_CLEAR: begin
        if (item.source_mask[proc_idx] && r_next) begin
          s_next       = ST_NONE;
          e_next.timer = '0;
        end
      end
      OP_VALIDATE: begin
        if (item.source_mask[proc_idx] && r_next &&
            (s_next == ST_NONE || s_next == ST_PENDING)) begin
          s_next       = ST_VALIDATED;
          e_next.timer = '0;
        end
      end
      OP_TICK: begin
        if (r_next && s_next == ST_PENDING) begin
          e_next.timer = tsum[16] ? 16'hFFFF : tsum[15:0];
          if (rd_data.timeout != TIMEOUT_NEVER && e_next.timer >= rd_data.timeout) begin
            s_next = ST_EXPIRED;
          end
          if (rd_data.countdown != '0) begin
            e_next.countdown = rd_data.countdown - 16'd1;
            if (e_next.countdown == '0) begin
              s_next = ST_EXPIRED;
            end
          end
        end
      end
      OP_CHANNEL: begin
        if (!found && r_next && rd_data.channel_en && rd_data.channel == item.channel) begin
          found_next = 1'b1;
          set_ev     = 1'b1;
        end
      end
      OP_CHECK_HOOK: begin
        set_ev = module_enabled && item.source_mask[proc_idx] && r_next && rd_data.check_en;
      end
      default: ;
    endcase
    // A set event (module enabled, slot not disabled) raises a registered slot to
    // pending, then validates it at once when the application check bit is set.
    if (set_ev && module_enabled && !disabled_mask[proc_idx]) begin
      if (r_next && s_next == ST_NONE) begin
        s_next       = ST_PENDING;
        e_next.timer = '0;
      end
      if (item.check_valid_mask[proc_idx] && r_next &&
          (s_next == ST_NONE || s_next == ST_PENDING)) begin
        s_next       = ST_VALIDATED;
        e_next.timer = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_q <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        stat[i] <= ST_NONE;
      end
    end else if (proc_vld) begin
      reg_q[proc_idx] <= r_next;
      stat[proc_idx]  <= s_next;
    end
  end

  // Result assembly from the flip-flop marks once the walk is complete.
  always_comb begin
    result = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (reg_q[i]) begin
        result.pending_mask[i]   = (stat[i] == ST_PENDING);
        result.validated_mask[i] = (stat[i] == ST_VALIDATED);
        result.expired_mask[i]   = (stat[i] == ST_EXPIRED);
      end
    end
    if (op_t'(item.op) == OP_QUERY && 32'(item.source_index) < NUM_SOURCES &&
        reg_q[item.source_index[IDX_W-1:0]]) begin
      result.source_status = stat[item.source_index[IDX_W-1:0]];
    end
    result.op_ok = ok;
  end

  // Transaction register, walk counter and per-transaction flags.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item  <= in_data;
      cnt   <= '0;
      found <= 1'b0;
      ok    <= !(op_t'(in_data.op) == OP_UNREGISTER &&
                 32'(in_data.source_index) >= NUM_SOURCES);
    end else begin
      if (state == S_WALK && !walk_end) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (proc_vld) begin
        ok    <= ok_next;
        found <= found_next;
      end
    end
  end

  // State and the output register. A result taken while a new one is ready
  // is replaced in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WSVT_ASSERT_NEXT(a_accept_busy, in_accept, in_stall, "input taken while busy")
  `WSVT_ASSERT_NOW(a_proc_in_walk, proc_vld, state == S_WALK, "slot update outside walk")
  `WSVT_ASSERT_NOW(a_masks_disjoint, out_valid,
    (out_data.pending_mask & out_data.validated_mask) == '0 &&
    (out_data.pending_mask & out_data.expired_mask) == '0, "status masks overlap")
  `WSVT_ASSERT_NOW(a_walk_bound, state == S_WALK, cnt <= CNT_W'(NUM_SOURCES),
    "walk counter overrun")

endmodule
